[src/fpa_pkg.sv]
`default_nettype none
package fpa_pkg;

   localparam int FRACTION_BITS = 8;
   // width of the scaled dividend magnitude, also the number of divider stages
   localparam int NUM_W = 32 + FRACTION_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic signed [31:0] WORD_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MAX      = 4'd10,
      OP_INC      = 4'd11,
      OP_DEC      = 4'd12,
      OP_FROM_INT = 4'd13,
      OP_TO_INT   = 4'd14
   } op_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic               overflow;
      logic               divide_by_zero;
   } rsp_type;

   // classified request as it sits in the front queue
   typedef struct packed {
      op_type             op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               cmp;
      logic               b_zero;
   } ent_type;

   // per request data that rides alongside the divider
   typedef struct packed {
      op_type             op;
      logic [31:0]        res;
      logic               ovf;
      logic               cmp;
      logic               dz;
      logic               neg;
      logic signed [63:0] prod;
   } side_type;

   function automatic logic [32:0] clamp_word(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > 64'sh000000007FFFFFFF) begin
         r = {1'b1, WORD_MAX};
      end else if (v < -64'sh0000000080000000) begin
         r = {1'b1, WORD_MIN};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/fixed_point_alu.sv]
// fixed_point_alu: Q(32-F).F fixed-point ALU, F = FRACTION_BITS (8 by default)
// request channel: write req_data when req_full is low by raising req_push;
//   the request is taken at that clock edge
// response channel: while rsp_empty is low, rsp_data holds the oldest response;
//   raise rsp_pop to take it
// every request gives exactly one response, in request order
// every request passes through the front queue, the first execute stage, the
//   bit-per-stage divider pipeline and the response queue
// throughput: one request per cycle unless the pipeline holds; the multiplier
//   works in one stage, the divider resolves one quotient bit per stage
// a 4-entry request queue sits between the decode front and the execute back,
//   and a 2-entry response queue sits at the output
// when the receiver stops popping, the response queue fills, the execute
//   pipeline holds, then the request queue fills and req_full rises
// reset: synchronous, active high; all queues empty, nothing in flight
`default_nettype none
module fixed_point_alu (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire fpa_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output fpa_pkg::rsp_type      rsp_data
);
   import fpa_pkg::*;

   logic    q_valid;
   logic    q_pop;
   ent_type q_head;

   fpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_head   (q_head)
   );

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[src/fpa_front.sv]
`default_nettype none
module fpa_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire fpa_pkg::req_type req_data,
   output logic                 q_valid,
   input  wire logic            q_pop,
   output fpa_pkg::ent_type     q_head
);
   import fpa_pkg::*;

   ent_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   ent_type               ent;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      ent.op     = op_type'(req_data.operation);
      ent.a      = req_data.operand_a;
      ent.b      = req_data.operand_b;
      ent.b_zero = (req_data.operand_b == 32'sd0);
      unique case (ent.op)
         OP_GT:   ent.cmp = req_data.operand_a >  req_data.operand_b;
         OP_LT:   ent.cmp = req_data.operand_a <  req_data.operand_b;
         OP_GE:   ent.cmp = req_data.operand_a >= req_data.operand_b;
         OP_LE:   ent.cmp = req_data.operand_a <= req_data.operand_b;
         OP_EQ:   ent.cmp = req_data.operand_a == req_data.operand_b;
         OP_NE:   ent.cmp = req_data.operand_a != req_data.operand_b;
         default: ent.cmp = 1'b0;
      endcase
   end

   assign req_full = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_head   = mem_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule
`default_nettype wire

[src/fpa_div.sv]
`default_nettype none
module fpa_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [fpa_pkg::NUM_W-1:0] in_num,
   input  wire logic [31:0]        in_den,
   input  wire fpa_pkg::side_type  in_side,
   output logic                    out_valid,
   output logic [fpa_pkg::NUM_W-1:0] out_quo,
   output logic [31:0]             out_rem,
   output logic [31:0]             out_den,
   output fpa_pkg::side_type       out_side
);
   import fpa_pkg::*;

   // one quotient bit per stage, restoring
   logic              valid_ff [NUM_W];
   logic [31:0]       rem_ff   [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [NUM_W-1:0]  quo_ff   [NUM_W];
   logic [31:0]       den_ff   [NUM_W];
   side_type          side_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              valid_prev;
      logic [31:0]       rem_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [NUM_W-1:0]  quo_prev;
      logic [31:0]       den_prev;
      side_type          side_prev;
      logic [32:0]       trial;
      logic              ge;
      logic [31:0]       rem_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign num_prev   = in_num;
         assign quo_prev   = '0;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign num_prev   = num_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, num_prev[NUM_W-1]};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? 32'(trial - {1'b0, den_prev}) : trial[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= {num_prev[NUM_W-2:0], 1'b0};
            quo_ff[k]  <= {quo_prev[NUM_W-2:0], ge};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_den   = den_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule
`default_nettype wire

[src/fpa_back.sv]
`default_nettype none
module fpa_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  q_pop,
   input  wire fpa_pkg::ent_type q_head,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output fpa_pkg::rsp_type      rsp_data
);
   import fpa_pkg::*;

   logic              advance;
   side_type          side_in;
   logic [NUM_W-1:0]  na_in;
   logic [31:0]       nb_in;
   logic signed [63:0] a64, b64, wide;
   logic [32:0]       clamped;
   logic [31:0]       abs_a, abs_b;

   logic              s1_valid_ff;
   side_type          s1_side_ff;
   logic [NUM_W-1:0]  s1_na_ff;
   logic [31:0]       s1_nb_ff;

   logic              d_valid;
   logic [NUM_W-1:0]  d_quo;
   logic [31:0]       d_rem;
   logic [31:0]       d_den;
   side_type          d_side;

   logic              round_up;
   logic [63:0]       abs_prod;
   logic [63:0]       mag;
   logic              neg;
   logic              ovf_mag;
   rsp_type           fin;

   rsp_type           fifo_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        cnt_ff, cnt_in;
   logic              fifo_full, fifo_wr, fifo_rd;

   assign fifo_full = (cnt_ff == 2'd2);
   assign advance   = !(d_valid && fifo_full);
   assign q_pop     = advance && q_valid;

   // first execute stage: simple ops finish here, multiply and divide set up
   always_comb begin
      a64   = {{32{q_head.a[31]}}, q_head.a};
      b64   = {{32{q_head.b[31]}}, q_head.b};
      abs_a = q_head.a[31] ? 32'(~q_head.a + 32'd1) : q_head.a;
      abs_b = q_head.b[31] ? 32'(~q_head.b + 32'd1) : q_head.b;
      na_in = {abs_a, {FRACTION_BITS{1'b0}}};
      nb_in = abs_b;
      wide  = '0;
      unique case (q_head.op)
         OP_ADD:      wide = a64 + b64;
         OP_SUB:      wide = a64 - b64;
         OP_MAX:      wide = (q_head.a > q_head.b) ? a64 : b64;
         OP_INC:      wide = a64 + 64'sd1;
         OP_DEC:      wide = a64 - 64'sd1;
         OP_FROM_INT: wide = a64 <<< FRACTION_BITS;
         OP_TO_INT:   wide = a64 >>> FRACTION_BITS;
         default:     wide = '0;
      endcase
      clamped      = clamp_word(wide);
      side_in.op   = q_head.op;
      side_in.cmp  = q_head.cmp;
      side_in.neg  = q_head.a[31] ^ q_head.b[31];
      side_in.prod = a64 * b64;
      side_in.res  = clamped[31:0];
      side_in.ovf  = clamped[32];
      side_in.dz   = 1'b0;
      if (q_head.op == OP_DIV && q_head.b_zero) begin
         side_in.dz  = 1'b1;
         side_in.ovf = 1'b0;
         if (q_head.a > 32'sd0) begin
            side_in.res = WORD_MAX;
         end else if (q_head.a < 32'sd0) begin
            side_in.res = WORD_MIN;
         end else begin
            side_in.res = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff <= side_in;
         s1_na_ff   <= na_in;
         s1_nb_ff   <= nb_in;
      end
   end

   fpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_na_ff),
      .in_den    (s1_nb_ff),
      .in_side   (s1_side_ff),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_rem   (d_rem),
      .out_den   (d_den),
      .out_side  (d_side)
   );

   // rounding and saturation of products and quotients
   always_comb begin
      round_up = ({d_rem, 1'b0} >= {1'b0, d_den});
      abs_prod = d_side.prod[63] ? 64'(-d_side.prod) : 64'(d_side.prod);
      if (d_side.op == OP_MUL) begin
         mag = (abs_prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
         neg = d_side.prod[63];
      end else begin
         mag = 64'(d_quo) + 64'(round_up);
         neg = d_side.neg;
      end
      ovf_mag = neg ? (mag > 64'h0000_0000_8000_0000) : (mag > 64'h0000_0000_7FFF_FFFF);
      fin.compare_true   = d_side.cmp;
      fin.divide_by_zero = d_side.dz;
      fin.result_value   = d_side.res;
      fin.overflow       = d_side.ovf;
      if (d_side.op == OP_MUL || (d_side.op == OP_DIV && !d_side.dz)) begin
         fin.overflow = ovf_mag;
         if (ovf_mag) begin
            fin.result_value = neg ? WORD_MIN : WORD_MAX;
         end else begin
            fin.result_value = neg ? 32'(-mag[31:0]) : mag[31:0];
         end
      end
   end

   assign fifo_wr   = advance && d_valid;
   assign rsp_empty = (cnt_ff == 2'd0);
   assign fifo_rd   = rsp_pop && !rsp_empty;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (fifo_wr && !fifo_rd) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!fifo_wr && fifo_rd) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ fifo_wr;
         rd_ptr_ff <= rd_ptr_ff ^ fifo_rd;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_ff[wr_ptr_ff] <= fin;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      !(fifo_wr && fifo_full))
      else $error("result queue written while full");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      fifo_wr && fin.divide_by_zero |-> !fin.overflow && !fin.compare_true)
      else $error("divide by zero request also flagged overflow");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      d_valid && !advance |=> d_valid)
      else $error("divider output lost during stall");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   localparam int LATENCY = FRACTION_BITS + 34;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;

   fixed_point_alu i_dut (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rsp_type expected_rsps[$];
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;

   function automatic logic signed [63:0] saturate(input logic signed [63:0] v,
                                                   inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // exact fixed-point arithmetic on wide integers
   function automatic rsp_type alu_result(input req_type rq);
      rsp_type r;
      logic signed [63:0] a, b, v;
      logic [127:0] mag, den, q;
      logic neg, ovf;
      a = rq.operand_a;
      b = rq.operand_b;
      v = 0;
      ovf = 1'b0;
      r = '0;
      case (rq.operation)
         OP_ADD: v = saturate(a + b, ovf);
         OP_SUB: v = saturate(a - b, ovf);
         OP_MUL: begin
            v = a * b;
            neg = v < 0;
            mag = neg ? -v : v;
            mag = (mag + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
            v = neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
            v = saturate(v, ovf);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
               v = a > 0 ? 64'sd2147483647 : (a < 0 ? -64'sd2147483648 : 0);
            end else begin
               neg = (a < 0) != (b < 0);
               mag = (a < 0 ? -a : a);
               mag = mag << FRACTION_BITS;
               den = (b < 0 ? -b : b);
               q = (2 * mag + den) / (2 * den);
               v = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
               v = saturate(v, ovf);
            end
         end
         OP_GT: r.compare_true = a > b;
         OP_LT: r.compare_true = a < b;
         OP_GE: r.compare_true = a >= b;
         OP_LE: r.compare_true = a <= b;
         OP_EQ: r.compare_true = a == b;
         OP_NE: r.compare_true = a != b;
         OP_MAX: v = a > b ? a : b;
         OP_INC: v = saturate(a + 1, ovf);
         OP_DEC: v = saturate(a - 1, ovf);
         OP_FROM_INT: v = saturate(a * (64'sd1 <<< FRACTION_BITS), ovf);
         OP_TO_INT: v = a >>> FRACTION_BITS;
         default: v = 0;
      endcase
      r.result_value = v[31:0];
      r.overflow = ovf;
      return r;
   endfunction

   // req_push stays high after a request so back to back requests need no gap
   task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                               input logic [31:0] b);
      req_type rq;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      rq.operation = op;
      rq.operand_a = a;
      rq.operand_b = b;
      req_push <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_rsps.push_back(alu_result(rq));
      sent_count++;
   endtask

   // response checker and stall generator
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            checked_count++;
            if (e.result_value !== rsp_data.result_value)
               $display("%0t: result_value expected %h actual %h", $time,
                        e.result_value, rsp_data.result_value);
            if (e.compare_true !== rsp_data.compare_true)
               $display("%0t: compare_true expected %b actual %b", $time,
                        e.compare_true, rsp_data.compare_true);
            if (e.overflow !== rsp_data.overflow)
               $display("%0t: overflow expected %b actual %b", $time,
                        e.overflow, rsp_data.overflow);
            if (e.divide_by_zero !== rsp_data.divide_by_zero)
               $display("%0t: divide_by_zero expected %b actual %b", $time,
                        e.divide_by_zero, rsp_data.divide_by_zero);
            if (e !== rsp_data) error_count++;
         end
      end
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF - $urandom_range(2);
         1: return 32'h80000000 + $urandom_range(2);
         2: return $urandom_range(512) - 256;
         3: return $urandom_range(65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] ext[6] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h100,
                              32'hFFFFFF00, 32'hFFFFFFFF};
      send_request(OP_DIV, 32'h100, 32'h0);
      send_request(OP_DIV, 32'hFFFFFF00, 32'h0);
      send_request(OP_DIV, 32'h0, 32'h0);
      send_request(OP_INC, 32'h7FFFFFFF, 32'h0);
      send_request(OP_DEC, 32'h80000000, 32'h0);
      send_request(OP_MUL, 32'h80, 32'h1);       // exact half rounds away
      send_request(OP_MUL, 32'hFFFFFF80, 32'h1);
      send_request(OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_request(OP_DIV, 32'h7FFFFFFF, 32'h1);
      send_request(OP_TO_INT, 32'hFFFFFFFF, 32'h0);
      send_request(OP_FROM_INT, 32'h80000000, 32'h0);
      send_request(OP_MAX, 32'h5, 32'h5);
      send_request(4'd15, 32'h1234, 32'h5678);   // unused code
      for (int op = 0; op < 15; op++)
         send_request(op[3:0], ext[$urandom_range(5)], ext[$urandom_range(5)]);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++)
         send_request(4'($urandom_range(15)), rand_operand(), rand_operand());
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200);
      send_idle_pct = 52;
      test_random(200);
      send_idle_pct = 0;
      pop_stall_pct = 52;
      test_random(200);
      send_idle_pct = 10;
      pop_stall_pct = 10;
      test_random(250);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d requests across four idle/stall phases, checked %0d",
               sent_count, checked_count);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

[fixed_point_alu.f]
src/fpa_pkg.sv
src/fpa_front.sv
src/fpa_div.sv
src/fpa_back.sv
src/fixed_point_alu.sv
tb/sv/tb.sv
